// ----- rtl/radix2_fft_real_input_core_defines.svh -----
// Assertion macros shared by the FFT core.
// No dependencies.
`ifndef RADIX2_FFT_REAL_INPUT_CORE_DEFINES_SVH
`define RADIX2_FFT_REAL_INPUT_CORE_DEFINES_SVH
// property that must hold on every clock outside reset
`define FFT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked on the next clock
`define FFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/r2fft_pkg.sv -----
// Package of the FFT core: widths, state codes and the twiddle table.
// No dependencies.
package r2fft_pkg;
   localparam int SAMPLE_W = 16;
   localparam int DATA_W   = 23;
   localparam int TW_W     = 17;
   localparam int DEPTH    = 64;
   localparam int ADDR_W   = 6;
   localparam logic signed [DATA_W-1:0] SAT_POS = 23'sd2097152;
   localparam logic signed [DATA_W-1:0] SAT_NEG = -23'sd2097152;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [TW_W-1:0]   tw_type;

   localparam logic [2:0] ST_LOAD = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_RDA  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_WRA  = 3'd4;
   localparam logic [2:0] ST_WRB  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;
   localparam logic [2:0] ST_RDB  = 3'd7;

   function automatic tw_type qcos(input logic [4:0] j);
      unique case (j)
         5'd0: qcos = 17'sd32768;  5'd1: qcos = 17'sd32610;  5'd2: qcos = 17'sd32138;
         5'd3: qcos = 17'sd31357;  5'd4: qcos = 17'sd30274;  5'd5: qcos = 17'sd28899;
         5'd6: qcos = 17'sd27246;  5'd7: qcos = 17'sd25330;  5'd8: qcos = 17'sd23170;
         5'd9: qcos = 17'sd20788;  5'd10: qcos = 17'sd18205; 5'd11: qcos = 17'sd15447;
         5'd12: qcos = 17'sd12540; 5'd13: qcos = 17'sd9512;  5'd14: qcos = 17'sd6393;
         5'd15: qcos = 17'sd3212;  default: qcos = 17'sd0;
      endcase
   endfunction

   function automatic tw_type rom_cos(input logic [ADDR_W-1:0] t);
      if (t <= 6'd16)      rom_cos = qcos(5'(t));
      else if (t <= 6'd32) rom_cos = -qcos(5'(6'd32 - t));
      else if (t <= 6'd48) rom_cos = -qcos(5'(t - 6'd32));
      else                 rom_cos = qcos(5'(7'd64 - {1'b0, t}));
   endfunction

   function automatic data_type sat21(input logic signed [DATA_W:0] v);
      if (v > 24'sd2097152)       sat21 = SAT_POS;
      else if (v < -24'sd2097152) sat21 = SAT_NEG;
      else                        sat21 = DATA_W'(v);
   endfunction
endpackage

// ----- rtl/r2fft_if.sv -----
// Valid/ready channel interfaces for the FFT core.
// Depends on r2fft_pkg.
interface r2fft_req_if import r2fft_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic last;
   modport source (output valid, sample, last, input ready);
   modport sink (input valid, sample, last, output ready);
endinterface

interface r2fft_rsp_if import r2fft_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [DATA_W-1:0] bin_real;
   logic signed [DATA_W-1:0] bin_imag;
   logic bin_last;
   modport source (output valid, bin_real, bin_imag, bin_last, input ready);
   modport sink (input valid, bin_real, bin_imag, bin_last, output ready);
endinterface

// ----- rtl/radix2_fft_real_input_core.sv -----
// Radix-2 DIT FFT core for frames of real samples, one shared butterfly.
// Depends on r2fft_pkg, r2fft_if and the defines header.
//
// Usage: samples arrive one beat per cycle on req_ (sample, last). A frame
// ends on the beat with last set or on sample min(MAX_POINTS, DEPTH).
// The frame is zero-padded to m = next power of two and transformed in
// place; the bit-reversed order is applied as an address permutation on
// the butterfly and bin reads, so samples stay at their natural index.
// A single butterfly unit does every butterfly: read a, read b, multiply,
// write a, write b; (m/2)*log2(m) butterflies make a transform; padding
// zeroes the slots after the last sample. The m bins then leave on rsp_
// through a registered read and the output register; a bin read waits
// until the previous one has landed; bin_last flags the final beat.
// req_ready is low from the frame's end until the read of the last bin has
// been issued. A stalled sink holds the output register and the bin reads.
// Reset (synchronous) returns to loading with an empty frame; the work store
// is not cleared, every entry is written before it is read.
`include "radix2_fft_real_input_core_defines.svh"
module radix2_fft_real_input_core import r2fft_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input logic clock,
   input logic reset,
   r2fft_req_if.sink req,
   r2fft_rsp_if.source rsp
);
   localparam int CAP = (MAX_POINTS > DEPTH) ? DEPTH : ((MAX_POINTS < 1) ? 1 : MAX_POINTS);

   data_type mem_re [DEPTH];
   data_type mem_im [DEPTH];

   logic [2:0] state_ff, state_in;
   logic [ADDR_W:0] count_ff, count_in;      // samples loaded
   logic [ADDR_W:0] m_ff, m_in;              // transform size
   logic [2:0] bits_ff, bits_in;
   logic [2:0] stage_ff, stage_in;           // log2(half)
   logic [ADDR_W:0] idx_ff, idx_in;          // pad index, butterfly index, bin index
   data_type ar_ff, ai_ff;
   data_type rd_re_ff, rd_im_ff;
   logic signed [40:0] pr_ff, pi_ff;
   logic out_valid_ff;
   data_type out_re_ff, out_im_ff;
   logic out_last_ff;
   logic bin_pend_ff, bin_last_pend_ff;

   logic [ADDR_W-1:0] half_w, k_w, a_addr, b_addr, tw_idx, ld_addr, bin_addr;
   logic [ADDR_W:0] m_next;
   logic [2:0] bits_next;
   tw_type c_w, s_w;

   // bit reversal over bits_ff of the physical slot
   function automatic logic [ADDR_W-1:0] brev(input logic [ADDR_W-1:0] v, input logic [2:0] b);
      logic [ADDR_W-1:0] r;
      r = '0;
      for (int i = 0; i < ADDR_W; i++)
         if (i < b) r[b-1-i] = v[i];
      return r;
   endfunction

   always_comb begin
      half_w = ADDR_W'(1 << stage_ff);
      k_w    = ADDR_W'(idx_ff) & (half_w - 1'b1);
      a_addr = ((ADDR_W'(idx_ff) & ~(half_w - 1'b1)) << 1) | k_w;
      b_addr = a_addr | half_w;
      tw_idx = ADDR_W'(k_w << (3'd5 - stage_ff));
      c_w    = rom_cos(tw_idx);
      s_w    = rom_cos(tw_idx + 6'd48);
      ld_addr = ADDR_W'(count_ff);
      bin_addr = ADDR_W'(idx_ff);
      m_next = 7'd1; bits_next = 3'd0;
      for (int i = 0; i < 7; i++)
         if (m_next < count_ff + 7'd1 && bits_next < 3'd6) begin
            m_next = m_next << 1; bits_next = bits_next + 3'd1;
         end
   end

   // Store holds entries in bit-reversed order during the butterflies:
   // logical position p lives at brev(p). Loading writes sample i to slot i,
   // which after zero-padding is logical brev(i); the DIT stages are run on
   // logical addresses mapped through brev, and output reads brev(bin).
   logic [ADDR_W-1:0] pa, pb, rd_addr;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   data_type wr_re, wr_im;
   logic signed [DATA_W:0] sum_re, sum_im;
   logic signed [DATA_W:0] tr_w, ti_w;

   always_comb begin
      pa = brev(a_addr, bits_ff);
      pb = brev(b_addr, bits_ff);
      tr_w = 24'((pr_ff + 41'sd16384) >>> 15);
      ti_w = 24'((pi_ff + 41'sd16384) >>> 15);
      sum_re = (state_ff == ST_WRA) ? (24'(ar_ff) + tr_w) : (24'(ar_ff) - tr_w);
      sum_im = (state_ff == ST_WRA) ? (24'(ai_ff) + ti_w) : (24'(ai_ff) - ti_w);
      rd_addr = (state_ff == ST_RDB) ? pb : ((state_ff == ST_OUT) ? brev(bin_addr, bits_ff) : pa);
      wr_en = 1'b0; wr_addr = pa; wr_re = sat21(sum_re); wr_im = sat21(sum_im);
      unique case (state_ff)
         ST_LOAD: begin
            wr_en = req.valid; wr_addr = ld_addr;
            wr_re = DATA_W'(req.sample); wr_im = '0;
         end
         ST_PAD: begin
            wr_en = 1'b1; wr_addr = ADDR_W'(idx_ff); wr_re = '0; wr_im = '0;
         end
         ST_WRA: wr_en = 1'b1;
         ST_WRB: begin wr_en = 1'b1; wr_addr = pb; end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_re[wr_addr] <= wr_re;
         mem_im[wr_addr] <= wr_im;
      end
      rd_re_ff <= mem_re[rd_addr];
      rd_im_ff <= mem_im[rd_addr];
   end

   // issue a bin read only when the output register is sure to be free on landing
   logic out_take;
   assign out_take = !bin_pend_ff && (!out_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff; count_in = count_ff; m_in = m_ff; bits_in = bits_ff;
      stage_in = stage_ff; idx_in = idx_ff;
      unique case (state_ff)
         ST_LOAD: if (req.valid) begin
            count_in = count_ff + 1'b1;
            if (req.last || count_in >= 7'(CAP)) begin
               m_in = m_next; bits_in = bits_next; idx_in = count_in;
               stage_in = '0;
               state_in = (count_in < m_next) ? ST_PAD : ((m_next == 7'd1) ? ST_OUT : ST_RDA);
               if (m_next == 7'd1 || count_in >= m_next) idx_in = '0;
            end
         end
         ST_PAD: begin
            idx_in = idx_ff + 1'b1;
            if (idx_in == m_ff) begin
               idx_in = '0;
               state_in = (m_ff == 7'd1) ? ST_OUT : ST_RDA;
            end
         end
         ST_RDA: state_in = ST_RDB;
         ST_RDB: state_in = ST_MUL;
         ST_MUL: state_in = ST_WRA;
         ST_WRA: state_in = ST_WRB;
         ST_WRB: begin
            state_in = ST_RDA;
            idx_in = idx_ff + 1'b1;
            if (idx_in == (m_ff >> 1)) begin
               idx_in = '0;
               stage_in = stage_ff + 1'b1;
               if (stage_in == bits_ff) state_in = ST_OUT;
            end
         end
         default: if (out_take) begin   // ST_OUT: one read issued per free slot
            idx_in = idx_ff + 1'b1;
            if (idx_in == m_ff) begin
               state_in = ST_LOAD; count_in = '0; idx_in = '0;
            end
         end
      endcase
   end

   // the bin read lands in the following cycle; track it
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; count_ff <= '0; idx_ff <= '0; stage_ff <= '0;
         m_ff <= 7'd1; bits_ff <= '0; out_valid_ff <= 1'b0; bin_pend_ff <= 1'b0;
         bin_last_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; idx_ff <= idx_in;
         stage_ff <= stage_in; m_ff <= m_in; bits_ff <= bits_in;
         bin_pend_ff <= (state_ff == ST_OUT) && out_take;
         bin_last_pend_ff <= (idx_ff + 1'b1 == m_ff);
         if (bin_pend_ff) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
      if (state_ff == ST_RDB) begin ar_ff <= rd_re_ff; ai_ff <= rd_im_ff; end
      if (bin_pend_ff) begin
         out_re_ff <= rd_re_ff; out_im_ff <= rd_im_ff; out_last_ff <= bin_last_pend_ff;
      end
   end

   // product of b and the twiddle, registered before the butterfly adds
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         pr_ff <= 41'(rd_re_ff * c_w) - 41'(rd_im_ff * s_w);
         pi_ff <= 41'(rd_re_ff * s_w) + 41'(rd_im_ff * c_w);
      end
   end

   assign req.ready = (state_ff == ST_LOAD);
   assign rsp.valid = out_valid_ff;
   assign rsp.bin_real = out_re_ff;
   assign rsp.bin_imag = out_im_ff;
   assign rsp.bin_last = out_last_ff;

   `FFT_ASSERT(a_ready_load, clock, reset, req.ready == (state_ff == ST_LOAD), "ready outside load")
   `FFT_ASSERT(a_cnt_cap, clock, reset, count_ff <= 7'(CAP), "sample count beyond cap")
   `FFT_ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.bin_real), "stalled bin changed")
   `FFT_ASSERT(a_m_pow2, clock, reset, $onehot(m_ff), "transform size not a power of two")
endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for the real-input radix-2 FFT core.
// Depends on r2fft_pkg, r2fft_req_if, r2fft_rsp_if and the core from the RTL.
module tb_top;
   import r2fft_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_CAP = 64;

   typedef struct {
      data_type re;
      data_type im;
      logic     last;
   } bin_type;

   typedef struct {
      int smp;
      bit lst;
      bit typed;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   r2fft_req_if req ();
   r2fft_rsp_if rsp ();

   radix2_fft_real_input_core #(.MAX_POINTS(FRAME_CAP)) DUT (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round(32768*cos(2*pi*j/64)), j = 0..16
   int quarter_wave [17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                             23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

   longint  frame_re [FRAME_CAP];
   longint  frame_im [FRAME_CAP];
   int      frame_len = 0;
   bin_type spectrum_q [$];
   int      errors = 0;
   bit      idle_on = 1'b1;
   bit      cur_typed = 1'b0;

   function automatic longint twiddle_cos(int t);
      t = t & 63;
      if (t <= 16) return quarter_wave[t];
      if (t <= 32) return -quarter_wave[32 - t];
      if (t <= 48) return -quarter_wave[t - 32];
      return quarter_wave[64 - t];
   endfunction

   function automatic longint clamp21(longint v);
      if (v > 2097152) return 2097152;
      if (v < -2097152) return -2097152;
      return v;
   endfunction

   function automatic longint q15_round(longint p);
      return (p + 16384) >>> 15;
   endfunction

   // load one sample; when the frame closes, transform and queue the bins
   function automatic void load_sample(int smp, bit lst, bit typed);
      int m, bits, j, r, len, half, st, k;
      longint c, s, br, bi, tr, ti, ar, ai;
      bin_type b;
      frame_re[frame_len] = smp;
      frame_im[frame_len] = 0;
      frame_len++;
      if (!lst && frame_len < FRAME_CAP) return;
      m = 1;
      bits = 0;
      while (m < frame_len) begin
         m = m << 1;
         bits++;
      end
      for (int i = frame_len; i < m; i++) begin
         frame_re[i] = 0;
         frame_im[i] = 0;
      end
      for (int i = 0; i < m; i++) begin
         r = 0;
         j = i;
         for (int q = 0; q < bits; q++) begin
            r = (r << 1) | (j & 1);
            j = j >> 1;
         end
         if (r > i) begin
            tr = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = tr;
            ti = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = ti;
         end
      end
      for (len = 2; len <= m; len = len << 1) begin
         half = len >> 1;
         for (st = 0; st < m; st += len) begin
            for (k = 0; k < half; k++) begin
               c  = twiddle_cos(k * (64 / len));
               s  = twiddle_cos(k * (64 / len) + 48);
               br = frame_re[st + k + half];
               bi = frame_im[st + k + half];
               tr = q15_round(br * c - bi * s);
               ti = q15_round(br * s + bi * c);
               ar = frame_re[st + k];
               ai = frame_im[st + k];
               frame_re[st + k] = clamp21(ar + tr);
               frame_im[st + k] = clamp21(ai + ti);
               frame_re[st + k + half] = clamp21(ar - tr);
               frame_im[st + k + half] = clamp21(ai - ti);
            end
         end
      end
      for (int i = 0; i < m; i++) begin
         b.re = data_type'(frame_re[i]);
         b.im = data_type'(frame_im[i]);
         b.last = (i == m - 1);
         // a lone sample comes back unchanged, marked last
         if (typed) begin
            b.re = data_type'(smp);
            b.im = '0;
            b.last = 1'b1;
         end
         spectrum_q = {spectrum_q, b};
      end
      frame_len = 0;
   endfunction

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         load_sample(int'(req.sample), req.last, cur_typed);
   end

   always @(posedge clock) begin
      bin_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (spectrum_q.size() == 0) begin
            $display("%0t: bin expected none actual re=%0d im=%0d last=%0b", $realtime,
                     rsp.bin_real, rsp.bin_imag, rsp.bin_last);
            errors++;
         end else begin
            e = spectrum_q.pop_front();
            if (rsp.bin_real !== e.re) begin
               $display("%0t: bin_real expected %0d actual %0d", $realtime, e.re,
                        rsp.bin_real);
               errors++;
            end
            if (rsp.bin_imag !== e.im) begin
               $display("%0t: bin_imag expected %0d actual %0d", $realtime, e.im,
                        rsp.bin_imag);
               errors++;
            end
            if (rsp.bin_last !== e.last) begin
               $display("%0t: bin_last expected %0b actual %0b", $realtime, e.last,
                        rsp.bin_last);
               errors++;
            end
         end
      end
   end

   // sink side: stall at random unless in a quiet stretch
   always @(negedge clock) begin
      rsp.ready <= !(idle_on && $urandom_range(99) < 32);
   end

   // hold the beat until taken; the next call may drop valid for an idle gap, the end of stimulus drops it
   task automatic send_beat(int smp, bit lst, bit typed);
      while (idle_on && $urandom_range(99) < 32) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid  <= 1'b1;
      req.sample <= smp[15:0];
      req.last   <= lst;
      cur_typed  <= typed;
      do @(posedge clock); while (!(req.valid && req.ready));
      @(negedge clock);
   endtask

   function automatic int pick_sample(int mode);
      case (mode)
         0: return 32767;
         1: return -32768;
         2: return $urandom_range(1) ? 32767 : -32768;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   row_type directed [19];

   initial begin
      int items, len, mode;
      bit full;
      req.valid  = 1'b0;
      req.sample = '0;
      req.last   = 1'b0;
      rsp.ready  = 1'b0;
      directed = '{
         '{32767, 1, 1}, '{-32768, 1, 1}, '{0, 1, 1}, '{1, 1, 1}, '{-1, 1, 1},
         '{32767, 0, 0}, '{32767, 1, 0},
         '{-32768, 0, 0}, '{-32768, 0, 0}, '{-32768, 0, 0}, '{-32768, 1, 0},
         '{100, 0, 0}, '{-200, 0, 0}, '{300, 1, 0},
         '{12345, 0, 0}, '{-1, 0, 0}, '{32767, 0, 0}, '{-32768, 0, 0}, '{7, 1, 0}};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_beat(directed[i].smp, directed[i].lst, directed[i].typed);

      items = $size(directed);
      while (items < 200) begin
         idle_on = !(items >= 80 && items < 130);
         full = ($urandom_range(9) == 0);
         len = full ? FRAME_CAP :
               ($urandom_range(4) == 0) ? $urandom_range(9, FRAME_CAP) : $urandom_range(1, 8);
         mode = $urandom_range(5);
         for (int i = 0; i < len; i++)
            send_beat(pick_sample(mode), !full && i == len - 1, 1'b0);
         items += len;
      end
      req.valid <= 1'b0;
      idle_on = 1'b1;

      while (spectrum_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0 && spectrum_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
